@@ design/ipalp_pkg.sv @@
// ----------------------------------------------------------------------------
// ipalp_pkg
// Types, constants and parse functions of the IP address literal parser.
// ----------------------------------------------------------------------------
package ipalp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned GROUP_W = 16;
   localparam int unsigned GROUPS  = 8;
   localparam int unsigned ADDR_W  = 64;

   localparam int unsigned F_COLON  = 0;
   localparam int unsigned F_DC     = 1;
   localparam int unsigned F_PREVC  = 2;
   localparam int unsigned F_JUSTDC = 3;
   localparam int unsigned F_PEND   = 4;
   localparam int unsigned F_SEGDOT = 5;
   localparam int unsigned F_HEXBAD = 6;
   localparam int unsigned F_V6FAIL = 7;
   localparam int unsigned F_V4FAIL = 8;
   localparam int unsigned F_OCTDIG = 9;

   localparam logic [3:0] NAME_START = 4'd0;
   localparam logic [3:0] NAME_FULL  = 4'd9;
   localparam logic [3:0] NAME_STAR  = 4'd10;
   localparam logic [3:0] NAME_NONE  = 4'd15;

   localparam logic [31:0] LOOPBACK_V4 = 32'h7f00_0001;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef struct packed {
      logic [7:0]                      octet_accum;
      logic [2:0]                      octet_index;
      logic [31:0]                     v4_value;
      logic [15:0]                     group_accum;
      logic [2:0]                      group_digits;
      logic [GROUPS-1:0][GROUP_W-1:0]  left_groups;
      logic [GROUPS-1:0][GROUP_W-1:0]  right_groups;  // right list, newest at index 0
      logic [3:0]                      lgroup_count;
      logic [3:0]                      rgroup_count;
      logic [11:0]                     flags;
      logic [3:0]                      name_pos;
   } parse_state_type;

   function automatic logic [7:0] host_char(input logic [3:0] pos);
      case (pos)
         4'd0:    host_char = 8'h6c;
         4'd1:    host_char = 8'h6f;
         4'd2:    host_char = 8'h63;
         4'd3:    host_char = 8'h61;
         4'd4:    host_char = 8'h6c;
         4'd5:    host_char = 8'h68;
         4'd6:    host_char = 8'h6f;
         4'd7:    host_char = 8'h73;
         4'd8:    host_char = 8'h74;
         default: host_char = 8'h00;
      endcase
   endfunction

   // returns 16 when not a hex digit
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39)      hex_of = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) hex_of = 5'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) hex_of = 5'(c - 8'h37);
      else                               hex_of = 5'd16;
   endfunction

   function automatic parse_state_type seg_clear(input parse_state_type s);
      parse_state_type r;
      r = s;
      r.octet_accum  = '0;
      r.octet_index  = '0;
      r.v4_value     = '0;
      r.group_accum  = '0;
      r.group_digits = '0;
      r.flags[F_SEGDOT] = 1'b0;
      r.flags[F_HEXBAD] = 1'b0;
      r.flags[F_V4FAIL] = 1'b0;
      r.flags[F_OCTDIG] = 1'b0;
      return r;
   endfunction

   // bit 32 = valid, low bits = value
   function automatic logic [32:0] v4_done(input parse_state_type s);
      logic ok;
      ok = !s.flags[F_V4FAIL] && s.flags[F_OCTDIG] && (s.octet_index == 3'd3);
      return {ok, s.v4_value[23:0], s.octet_accum};
   endfunction

   function automatic parse_state_type push_group(input parse_state_type s,
                                                  input logic [15:0] v);
      parse_state_type r;
      logic [3:0] cnt;
      r = s;
      if (s.flags[F_DC]) begin
         cnt = s.rgroup_count;
         r.right_groups = {s.right_groups[GROUPS-2:0], v};
      end else begin
         cnt = s.lgroup_count;
         if (cnt < 4'd8) r.left_groups[cnt[2:0]] = v;
      end
      if (cnt < 4'd15) cnt = cnt + 4'd1;
      if (cnt > 4'd8) r.flags[F_V6FAIL] = 1'b1;
      if (s.flags[F_DC]) r.rgroup_count = cnt;
      else               r.lgroup_count = cnt;
      return r;
   endfunction

   function automatic parse_state_type seg_finish(input parse_state_type s);
      parse_state_type r;
      logic [32:0] q;
      r = s;
      q = v4_done(s);
      if (s.flags[F_SEGDOT]) begin
         if (q[32]) begin
            r = push_group(r, q[31:16]);
            r = push_group(r, q[15:0]);
         end else begin
            r.flags[F_V6FAIL] = 1'b1;
         end
      end else if (s.flags[F_HEXBAD] || s.group_digits > 3'd4 || s.group_digits == 3'd0) begin
         r.flags[F_V6FAIL] = 1'b1;
      end else begin
         r = push_group(r, s.group_accum);
      end
      return r;
   endfunction

   function automatic logic [3:0] name_next(input logic [3:0] pos, input logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
      if (pos < 4'd9 && lc == host_char(pos)) name_next = pos + 4'd1;
      else if (pos == NAME_START && c == CH_STAR) name_next = NAME_STAR;
      else name_next = NAME_NONE;
   endfunction

   function automatic parse_state_type v4_char(input parse_state_type s,
                                               input logic [7:0] c);
      parse_state_type r;
      logic [11:0] t;
      r = s;
      t = 12'(s.octet_accum) * 12'd10 + 12'(c - 8'h30);
      if (!s.flags[F_V4FAIL]) begin
         if (c >= 8'h30 && c <= 8'h39) begin
            if (t > 12'd255) r.flags[F_V4FAIL] = 1'b1;
            else begin
               r.octet_accum = t[7:0];
               r.flags[F_OCTDIG] = 1'b1;
            end
         end else if (c == CH_DOT) begin
            if (!s.flags[F_OCTDIG] || s.octet_index >= 3'd3) r.flags[F_V4FAIL] = 1'b1;
            else begin
               r.v4_value    = {s.v4_value[23:0], s.octet_accum};
               r.octet_index = s.octet_index + 3'd1;
               r.octet_accum = '0;
               r.flags[F_OCTDIG] = 1'b0;
            end
         end else begin
            r.flags[F_V4FAIL] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic parse_state_type take_char(input parse_state_type s,
                                                 input logic [7:0] c);
      parse_state_type r;
      logic [4:0] h;
      r = s;
      h = hex_of(c);
      r.name_pos = name_next(s.name_pos, c);
      if (c == CH_COLON) begin
         r.flags[F_COLON] = 1'b1;
         if (r.flags[F_PREVC]) begin
            if (r.flags[F_DC]) r.flags[F_V6FAIL] = 1'b1;
            else begin
               r.flags[F_DC]     = 1'b1;
               r.flags[F_JUSTDC] = 1'b1;
               r.flags[F_PEND]   = 1'b0;
            end
         end else begin
            if (r.group_digits == 3'd0) r.flags[F_PEND] = 1'b1;
            else begin
               if (r.flags[F_SEGDOT]) r.flags[F_PEND] = 1'b1;
               r = seg_finish(r);
            end
            r.flags[F_PREVC]  = 1'b1;
            r.flags[F_JUSTDC] = 1'b0;
         end
         r = seg_clear(r);
      end else begin
         if (r.flags[F_PREVC]) begin
            if (r.flags[F_PEND]) r.flags[F_V6FAIL] = 1'b1;
            r.flags[F_PEND]   = 1'b0;
            r.flags[F_PREVC]  = 1'b0;
            r.flags[F_JUSTDC] = 1'b0;
         end
         if (r.group_digits < 3'd7) r.group_digits = r.group_digits + 3'd1;
         if (c == CH_DOT) r.flags[F_SEGDOT] = 1'b1;
         if (!h[4]) r.group_accum = {r.group_accum[11:0], h[3:0]};
         else if (c != CH_DOT) r.flags[F_HEXBAD] = 1'b1;
         if (c == CH_PCT) r.flags[F_V6FAIL] = 1'b1;
         r = v4_char(r, c);
      end
      return r;
   endfunction

endpackage

@@ design/ipalp_if.sv @@
// ----------------------------------------------------------------------------
// ipalp channel interfaces
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface ipalp_req_if
   import ipalp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;
   modport source (output valid, char_code, is_last, input ready);
   modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface ipalp_rsp_if
   import ipalp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              ok;
   logic              is_v6;
   logic [ADDR_W-1:0] addr_high;
   logic [ADDR_W-1:0] addr_low;
   modport source (output valid, ok, is_v6, addr_high, addr_low, input ready);
   modport sink   (input valid, ok, is_v6, addr_high, addr_low, output ready);
endinterface

@@ design/ip_address_literal_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ip_address_literal_parser_unit
// Parses an IPv4 / IPv6 address literal streamed one character per item.
// ----------------------------------------------------------------------------
// req_if carries one character per item with is_last on the final one; a
// lone item with code 0 and is_last set is the empty string.
// rsp_if gives one item per string: ok, is_v6, addr_high, addr_low. Failed
// strings report all zero fields besides ok = 0.
// Every accepted character updates the parser registers in the same cycle,
// so one character is taken per clock while req_if.ready is high. The result
// is registered and shows on rsp_if in the cycle after the final character.
// req_if.ready is high whenever the result register is empty or is being
// taken; a stalled receiver holds the result and the next character waits,
// while characters keep flowing as long as the result register is free.
// Synchronous reset clears the parser state and drops rsp_if.valid; the
// group stores are not cleared, only entries written for the current string
// are used.
// ----------------------------------------------------------------------------
module ip_address_literal_parser_unit
   import ipalp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ipalp_req_if.sink    req_if,
   ipalp_rsp_if.source  rsp_if
);

   parse_state_type    state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               ok_ff, ok_in;
   logic               v6_ff, v6_in;
   logic [ADDR_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0]  lo_ff, lo_in;
   logic               req_fire;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      parse_state_type s1;
      parse_state_type s2;
      parse_state_type clr;
      logic [32:0]     q;
      logic            empty;
      logic            v6ok;
      logic [4:0]      sum;
      logic [GROUPS-1:0][GROUP_W-1:0] g;

      empty = (state_ff.name_pos == NAME_START) && (req_if.char_code == CH_NUL)
              && req_if.is_last;
      s1 = empty ? state_ff : take_char(state_ff, req_if.char_code);
      s2 = s1.flags[F_PREVC] ? s1 : seg_finish(s1);
      q  = v4_done(s1);
      sum = 5'(s2.lgroup_count) + 5'(s2.rgroup_count);

      v6ok = !s2.flags[F_V6FAIL];
      if (s1.flags[F_PREVC] && !s1.flags[F_JUSTDC]) v6ok = 1'b0;
      if (s2.flags[F_DC]) begin
         if (sum >= 5'd8) v6ok = 1'b0;
      end else if (s2.lgroup_count != 4'd8) begin
         v6ok = 1'b0;
      end

      for (int i = 0; i < GROUPS; i++) begin
         if (4'(i) < s2.lgroup_count)
            g[i] = s2.left_groups[i];
         else if (s2.flags[F_DC] && (5'(i) + 5'(s2.rgroup_count) >= 5'd8))
            g[i] = s2.right_groups[GROUPS-1-i];
         else
            g[i] = '0;
      end

      ok_in = 1'b0;
      v6_in = 1'b0;
      hi_in = '0;
      lo_in = '0;
      if (s1.name_pos == NAME_FULL) begin
         ok_in = 1'b1;
         lo_in = {32'd0, LOOPBACK_V4};
      end else if (empty || s1.name_pos == NAME_STAR) begin
         ok_in = 1'b1;
      end else if (s1.flags[F_COLON]) begin
         if (v6ok) begin
            ok_in = 1'b1;
            v6_in = 1'b1;
            hi_in = {g[0], g[1], g[2], g[3]};
            lo_in = {g[4], g[5], g[6], g[7]};
         end
      end else if (q[32]) begin
         ok_in = 1'b1;
         lo_in = {32'd0, q[31:0]};
      end

      clr              = seg_clear(s1);
      clr.lgroup_count = '0;
      clr.rgroup_count = '0;
      clr.flags        = '0;
      clr.name_pos     = NAME_START;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (req_fire) begin
         state_in = req_if.is_last ? clr : s1;
         if (req_if.is_last) rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.octet_accum  <= '0;
         state_ff.octet_index  <= '0;
         state_ff.v4_value     <= '0;
         state_ff.group_accum  <= '0;
         state_ff.group_digits <= '0;
         state_ff.lgroup_count <= '0;
         state_ff.rgroup_count <= '0;
         state_ff.flags        <= '0;
         state_ff.name_pos     <= NAME_START;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff.octet_accum  <= state_in.octet_accum;
         state_ff.octet_index  <= state_in.octet_index;
         state_ff.v4_value     <= state_in.v4_value;
         state_ff.group_accum  <= state_in.group_accum;
         state_ff.group_digits <= state_in.group_digits;
         state_ff.lgroup_count <= state_in.lgroup_count;
         state_ff.rgroup_count <= state_in.rgroup_count;
         state_ff.flags        <= state_in.flags;
         state_ff.name_pos     <= state_in.name_pos;
         rsp_valid_ff          <= rsp_valid_in;
      end
      state_ff.left_groups  <= state_in.left_groups;
      state_ff.right_groups <= state_in.right_groups;
      if (req_fire && req_if.is_last) begin
         ok_ff <= ok_in;
         v6_ff <= v6_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.ok        = ok_ff;
   assign rsp_if.is_v6     = v6_ff;
   assign rsp_if.addr_high = hi_ff;
   assign rsp_if.addr_low  = lo_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.is_last |=> rsp_valid_ff)
      else $error("last item did not produce a result");

   a_no_rsp_midstring: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_if.is_last && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result raised by a non-final item");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> !v6_ff && hi_ff == '0 && lo_ff == '0)
      else $error("failed result carries nonzero fields");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.is_last |=> state_ff.flags == '0 &&
         state_ff.lgroup_count == '0 && state_ff.rgroup_count == '0 &&
         state_ff.name_pos == NAME_START)
      else $error("parser state not cleared after string end");

endmodule
